### rtl/core/bcd_pkg.sv
`timescale 1ns / 1ps

package bcd_pkg;

    // Requested number of decimal digits, clamped to the supported range.
    localparam int DIGITS = 8;
    localparam int NDIG   = (DIGITS < 1) ? 1 : ((DIGITS > 8) ? 8 : DIGITS);

    // Datapath widths.
    localparam int DATA_W = 32;
    localparam int BCD_W  = 4 * NDIG;

    // Each cell performs this many shift-and-correct steps per cycle.
    localparam int BITS_PER_CELL = 4;
    localparam int NUM_CELLS     = DATA_W / BITS_PER_CELL;

    // Largest value that fits in NDIG decimal digits.
    function automatic logic [63:0] max_decimal(input int ndig);
        logic [63:0] acc;
        acc = 64'd1;
        for (int i = 0; i < ndig; i++) begin
            acc = acc * 64'd10;
        end
        return acc - 64'd1;
    endfunction

    localparam logic [DATA_W-1:0] LIMIT = DATA_W'(max_decimal(NDIG));

    // Payload carried from cell to cell.
    typedef struct packed {
        logic [DATA_W-1:0] bin;
        logic [BCD_W-1:0]  bcd;
        logic              oor;
    } t_stage;

    // True when every used nibble is a decimal digit and unused nibbles are zero.
    function automatic logic bcd_word_ok(input logic [DATA_W-1:0] word);
        logic ok;
        ok = 1'b1;
        for (int d = 0; d < DATA_W / 4; d++) begin
            if (d < NDIG) begin
                if (word[4*d +: 4] > 4'd9) begin
                    ok = 1'b0;
                end
            end else if (word[4*d +: 4] != 4'd0) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

### rtl/core/bcd_in_if.sv
`timescale 1ns / 1ps

interface bcd_in_if
    import bcd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] binary_value;

    modport source (output valid, output binary_value, input ready);
    modport sink   (input valid, input binary_value, output ready);
endinterface

### rtl/core/bcd_out_if.sv
`timescale 1ns / 1ps

interface bcd_out_if
    import bcd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] bcd_word;
    logic              out_of_range;

    modport source (output valid, output bcd_word, output out_of_range, input ready);
    modport sink   (input valid, input bcd_word, input out_of_range, output ready);
endinterface

### rtl/core/bcd_cell.sv
`timescale 1ns / 1ps

module bcd_cell
    import bcd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_stage i_data,
    output logic   o_valid,
    output t_stage o_data
);

    logic                      r_valid;
    t_stage                    r_data;
    t_stage                    n_data;
    logic [BCD_W+DATA_W-1:0]   acc;

    // Shift-and-add-3 steps on the combined digit and binary register.
    // Out-of-range items pass through untouched so the raw value survives.
    always_comb begin
        acc    = {i_data.bcd, i_data.bin};
        n_data = i_data;
        for (int k = 0; k < BITS_PER_CELL; k++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (acc[DATA_W + 4*d +: 4] >= 4'd5) begin
                    acc[DATA_W + 4*d +: 4] = acc[DATA_W + 4*d +: 4] + 4'd3;
                end
            end
            acc = acc << 1;
        end
        if (!i_data.oor) begin
            n_data.bcd = acc[DATA_W +: BCD_W];
            n_data.bin = acc[DATA_W-1:0];
        end
    end

    // Valid bit of this cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/binary_to_bcd_converter.sv
`timescale 1ns / 1ps
// Structure: a registered entry stage followed by a chain of NUM_CELLS registered cells.
// Throughput: one transfer per cycle; each cell of the chain performs four
// shift-and-add-3 steps, and the whole chain advances together.
// When the output stalls, the chain holds and input ready drops.
// Reset (synchronous, active low) clears all valid bits; data is not cleared.

module binary_to_bcd_converter
    import bcd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    bcd_in_if.sink       i_src,
    bcd_out_if.source    o_res
);

    logic   r_valid0;
    t_stage r_data0;
    logic   w_en;
    logic   w_valid [0:NUM_CELLS];
    t_stage w_data  [0:NUM_CELLS];

    // The chain moves whenever the last cell is empty or being drained.
    assign w_en        = !w_valid[NUM_CELLS] || o_res.ready;
    assign i_src.ready = w_en;

    // Entry stage: capture the value and decide the range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (w_en) begin
            r_valid0 <= i_src.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_data0.bin <= i_src.binary_value;
            r_data0.bcd <= '0;
            r_data0.oor <= (i_src.binary_value > LIMIT);
        end
    end

    assign w_valid[0] = r_valid0;
    assign w_data[0]  = r_data0;

    // Row of conversion cells.
    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[c]),
            .i_data  (w_data[c]),
            .o_valid (w_valid[c+1]),
            .o_data  (w_data[c+1])
        );
    end

    // Result: packed digits, or the raw value when it did not fit.
    assign o_res.valid        = w_valid[NUM_CELLS];
    assign o_res.out_of_range = w_data[NUM_CELLS].oor;
    assign o_res.bcd_word     = w_data[NUM_CELLS].oor ? w_data[NUM_CELLS].bin
                                                      : DATA_W'(w_data[NUM_CELLS].bcd);

endmodule

### rtl/core/bcd_checker.sv
`timescale 1ns / 1ps

module bcd_checker
    import bcd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_bcd_word,
    input logic              i_out_of_range
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_bcd_word) && $stable(i_out_of_range))
        else $error("result changed while stalled");

    // An empty output never blocks the input.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked while output empty");

    // A pass-through result must carry a value that does not fit.
    a_oor_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_of_range |-> i_bcd_word > LIMIT)
        else $error("out-of-range flag on a convertible value");

    // A converted result holds only decimal digits.
    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_of_range |-> bcd_word_ok(i_bcd_word))
        else $error("converted result has a non-decimal nibble");

    // No result right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result present after reset");

endmodule

bind binary_to_bcd_converter bcd_checker u_bcd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_src.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_bcd_word     (o_res.bcd_word),
    .i_out_of_range (o_res.out_of_range)
);

### tb/sv/tb_binary_to_bcd_converter.sv
`timescale 1ns / 1ps

module tb_binary_to_bcd_converter;
    import bcd_pkg::*;

    // Expected result of one conversion.
    typedef struct packed {
        logic [DATA_W-1:0] bcd_word;
        logic              out_of_range;
    } t_decimal_result;

    logic i_clk;
    logic i_rst_n;

    bcd_in_if  conv_in ();
    bcd_out_if conv_out ();

    binary_to_bcd_converter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (conv_in),
        .o_res   (conv_out)
    );

    t_decimal_result pending_decimal[$];
    int mismatch_count = 0;
    bit source_idles   = 1'b1;
    bit sink_idles     = 1'b1;
    int sink_hold_req  = 0;

    // Free-running clock, 10 ns period.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        repeat (200000) @(posedge i_clk);
        $display("[binary_to_bcd_converter] ERROR");
        $finish;
    end

    // Decimal form of a value, or the value itself with the flag when it is too large.
    function automatic t_decimal_result predict_decimal(input logic [DATA_W-1:0] value);
        t_decimal_result   res;
        longint unsigned   ceiling;
        logic [DATA_W-1:0] rest;
        ceiling = 1;
        for (int i = 0; i < NDIG; i++) begin
            ceiling = ceiling * 10;
        end
        if (longint'(value) > ceiling - 1) begin
            res.bcd_word     = value;
            res.out_of_range = 1'b1;
            return res;
        end
        res.bcd_word     = '0;
        res.out_of_range = 1'b0;
        rest             = value;
        for (int i = 0; i < NDIG; i++) begin
            res.bcd_word[4*i +: 4] = 4'(rest % 10);
            rest = rest / 10;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Offer one value and wait for its transfer; the expectation is queued on acceptance.
    task automatic send_value(input logic [DATA_W-1:0] value);
        int gap;
        gap = source_idles ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            conv_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        conv_in.valid        <= 1'b1;
        conv_in.binary_value <= value;
        do @(posedge i_clk); while (!conv_in.ready);
        pending_decimal.push_back(predict_decimal(value));
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_results();
        conv_in.valid <= 1'b0;
        while (pending_decimal.size() != 0) @(posedge i_clk);
    endtask

    // Result side: draws a stall per transfer and serves long hold requests.
    initial begin : result_sink
        int wait_cycles;
        conv_out.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (sink_hold_req > 0) begin
                wait_cycles   = sink_hold_req;
                sink_hold_req = 0;
            end else begin
                wait_cycles = sink_idles ? $urandom_range(0, 4) : 0;
            end
            if (wait_cycles > 0) begin
                conv_out.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            conv_out.ready <= 1'b1;
            do @(posedge i_clk); while (!conv_out.valid && sink_hold_req == 0);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_decimal_result exp_res;
        if (i_rst_n && conv_out.valid && conv_out.ready) begin
            if (pending_decimal.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", conv_out.bcd_word));
            end else begin
                exp_res = pending_decimal.pop_front();
                if (conv_out.bcd_word !== exp_res.bcd_word) begin
                    report_mismatch($sformatf("bcd_word %h, expected %h",
                                              conv_out.bcd_word, exp_res.bcd_word));
                end
                if (conv_out.out_of_range !== exp_res.out_of_range) begin
                    report_mismatch($sformatf("out_of_range %b, expected %b",
                                              conv_out.out_of_range, exp_res.out_of_range));
                end
            end
        end
    end

    // Field extremes, the largest convertible value and the first one past it.
    task automatic test_directed();
        logic [DATA_W-1:0] corner[] = '{
            32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd12345678, 32'd87654321,
            32'd90000000, 32'd99999998, 32'd99999999, 32'd100000000, 32'd100000001,
            32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
            32'h0000_FFFF, 32'd10000000, 32'd99999999
        };
        foreach (corner[i]) send_value(corner[i]);
    endtask

    // Mostly convertible values, with wide random words and values near the limit.
    task automatic test_random(input int count);
        logic [DATA_W-1:0] value;
        int kind;
        for (int n = 0; n < count; n++) begin
            // Change the idling pattern every block of items, including no idling.
            if (n % 150 == 0) begin
                source_idles = ($urandom_range(0, 3) != 0);
                sink_idles   = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                value = $urandom_range(0, 99999999);
            end else if (kind < 80) begin
                value = $urandom;
            end else if (kind < 90) begin
                value = 32'd99999999 + $urandom_range(0, 8) - 4;
            end else begin
                value = $urandom_range(0, 999);
            end
            send_value(value);
        end
        source_idles = 1'b1;
        sink_idles   = 1'b1;
    endtask

    // The result side holds off while values keep coming, so the input stalls.
    task automatic test_backpressure();
        source_idles  = 1'b0;
        sink_hold_req = 120;
        for (int n = 0; n < 40; n++) send_value($urandom);
        source_idles = 1'b1;
    endtask

    // The source pauses until every result is back, then resumes.
    task automatic test_drain_pause();
        for (int n = 0; n < 20; n++) send_value($urandom_range(0, 99999999));
        drain_results();
        for (int n = 0; n < 20; n++) send_value($urandom);
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        conv_in.valid        <= 1'b0;
        conv_in.binary_value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random(1250);
        test_drain_pause();

        // Let the chain empty, then allow its latency for stray results.
        drain_results();
        repeat (NUM_CELLS + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[binary_to_bcd_converter] OK");
        end else begin
            $display("[binary_to_bcd_converter] ERROR");
        end
        $finish;
    end

endmodule

### binary_to_bcd_converter.f
rtl/core/bcd_pkg.sv
rtl/core/bcd_in_if.sv
rtl/core/bcd_out_if.sv
rtl/core/bcd_cell.sv
rtl/core/binary_to_bcd_converter.sv
rtl/core/bcd_checker.sv
tb/sv/tb_binary_to_bcd_converter.sv
